@@ src/gcoc_pkg.sv @@
`default_nettype none
package gcoc_pkg;

   localparam int CountWidth = 15;

   localparam logic [1:0] MODE_SEQ    = 2'd0;
   localparam logic [1:0] MODE_PAT    = 2'd1;
   localparam logic [1:0] MODE_RUN    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] CSR_GAP_MASK_0 = 2'd0;
   localparam logic [1:0] CSR_GAP_MASK_1 = 2'd1;
   localparam logic [1:0] CSR_GAP_MASK_2 = 2'd2;
   localparam logic [1:0] CSR_GAP_MASK_3 = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol;
      logic       start_new;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] occurrences;
      logic                  input_truncated;
   } rsp_type;

   // Verdict of the compare unit for one scanned position.
   typedef struct packed {
      logic hit;
      logic violate;
      logic gap_ok_next;
   } step_type;

endpackage
`default_nettype wire

@@ src/gap_constrained_occurrence_counter_core.sv @@
`default_nettype none
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    mode, symbol, start_new
// rsp      out        rsp_valid/stall    occurrences, input_truncated
// csr      in         csr_wr_en          csr_index, csr_wr_data (64 bits)
//
// Load words are taken one per cycle and stream back to back while no run is in progress.
// A run word first clears the used marks, one position per cycle, then scans each
// position through the issue and evaluate states with the shared compare unit,
// and on a gap violation releases each marked position through a read and a write state.
// Reset is synchronous and active high; the stores keep no valid bits.
// The result waits in an output register while rsp_stall is high.
module gap_constrained_occurrence_counter_core
   import gcoc_pkg::*;
#(
   parameter int SEQ_DEPTH = 16384,
   parameter int PAT_MAX   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wr_data
);

   localparam int SAW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int SLW = $clog2(SEQ_DEPTH + 1);
   localparam int PAW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
   localparam int PLW = $clog2(PAT_MAX + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_REL_RD = 3'd4;
   localparam logic [2:0] ST_REL_WR = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [SLW-1:0]        seq_len_ff, seq_len_in;
   logic [PLW-1:0]        pat_len_ff, pat_len_in;
   logic                  trunc_ff, trunc_in;
   logic [SLW-1:0]        pos_ff, pos_in;
   logic [PAW-1:0]        j_ff, j_in;
   logic [PAW-1:0]        k_ff, k_in;
   logic [SAW-1:0]        first_ff, first_in;
   logic [SLW-1:0]        clr_ff, clr_in;
   logic                  gap_ok_ff, gap_ok_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [63:0]           gap_ff [4];

   logic                  req_accept;
   logic [SLW-1:0]        seq_len_eff;
   logic [PLW-1:0]        pat_len_eff;
   logic                  seq_wr_en, pat_wr_en, used_wr_en, mp_wr_en;
   logic [SAW-1:0]        used_wr_addr;
   logic                  used_wr_data;
   logic [7:0]            seq_rd, pat_rd;
   logic                  used_rd;
   logic [SAW-1:0]        mp_rd;
   logic [255:0]          gap_set;
   step_type              step;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign gap_set    = {gap_ff[3], gap_ff[2], gap_ff[1], gap_ff[0]};

   assign seq_len_eff = req_data.start_new ? '0 : seq_len_ff;
   assign pat_len_eff = req_data.start_new ? '0 : pat_len_ff;

   assign seq_wr_en = req_accept && (req_data.mode == MODE_SEQ)
                      && (seq_len_eff < SLW'(SEQ_DEPTH));
   assign pat_wr_en = req_accept && (req_data.mode == MODE_PAT)
                      && (pat_len_eff < PLW'(PAT_MAX));
   assign mp_wr_en  = (state_ff == ST_EVAL) && step.hit && !step.violate;

   always_comb begin
      used_wr_en   = 1'b0;
      used_wr_addr = pos_ff[SAW-1:0];
      used_wr_data = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            used_wr_en   = 1'b1;
            used_wr_addr = clr_ff[SAW-1:0];
         end
         ST_EVAL: begin
            used_wr_en   = mp_wr_en;
            used_wr_data = 1'b1;
         end
         ST_REL_WR: begin
            used_wr_en   = 1'b1;
            used_wr_addr = mp_rd;
         end
         default: begin
         end
      endcase
   end

   gcoc_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(8)) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_wr_en),
      .wr_addr (seq_len_eff[SAW-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (pos_ff[SAW-1:0]),
      .rd_data (seq_rd)
   );

   gcoc_ram #(.DEPTH(PAT_MAX), .WIDTH(8)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (pat_len_eff[PAW-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (j_ff),
      .rd_data (pat_rd)
   );

   gcoc_ram #(.DEPTH(SEQ_DEPTH), .WIDTH(1)) u_used_ram (
      .clock   (clock),
      .wr_en   (used_wr_en),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_addr (pos_ff[SAW-1:0]),
      .rd_data (used_rd)
   );

   gcoc_ram #(.DEPTH(PAT_MAX), .WIDTH(SAW)) u_pos_ram (
      .clock   (clock),
      .wr_en   (mp_wr_en),
      .wr_addr (j_ff),
      .wr_data (pos_ff[SAW-1:0]),
      .rd_addr (k_ff),
      .rd_data (mp_rd)
   );

   gcoc_step_unit u_step (
      .seq_byte     (seq_rd),
      .pat_byte     (pat_rd),
      .used         (used_rd),
      .gap_ok       (gap_ok_ff),
      .first_symbol (j_ff == '0),
      .gap_set      (gap_set),
      .step         (step)
   );

   always_comb begin
      state_in     = state_ff;
      seq_len_in   = seq_len_ff;
      pat_len_in   = pat_len_ff;
      trunc_in     = trunc_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      gap_ok_in    = gap_ok_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.mode)
                  MODE_SEQ: begin
                     if (seq_wr_en) begin
                        seq_len_in = seq_len_eff + SLW'(1);
                     end else begin
                        seq_len_in = seq_len_eff;
                        trunc_in   = 1'b1;
                     end
                  end
                  MODE_PAT: begin
                     if (pat_wr_en) begin
                        pat_len_in = pat_len_eff + PLW'(1);
                     end else begin
                        pat_len_in = pat_len_eff;
                        trunc_in   = 1'b1;
                     end
                  end
                  MODE_RUN: begin
                     count_in  = '0;
                     clr_in    = '0;
                     pos_in    = '0;
                     j_in      = '0;
                     gap_ok_in = 1'b1;
                     if (seq_len_ff == '0 || pat_len_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_CLEAR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + SLW'(1);
            if (clr_ff + SLW'(1) == seq_len_ff) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = (pos_ff >= seq_len_ff) ? ST_DONE : ST_EVAL;
         end
         ST_EVAL: begin
            gap_ok_in = step.gap_ok_next;
            state_in  = ST_ISSUE;
            if (step.violate) begin
               // Release the partial word's marks, then restart past its head.
               pos_in    = SLW'(first_ff) + SLW'(1);
               k_in      = '0;
               gap_ok_in = 1'b1;
               state_in  = ST_REL_RD;
            end else if (step.hit) begin
               if (j_ff == '0) begin
                  first_in = pos_ff[SAW-1:0];
               end
               if (PLW'(j_ff) + PLW'(1) == pat_len_ff) begin
                  count_in = count_ff + CountWidth'(1);
                  j_in     = '0;
                  pos_in   = (j_ff == '0) ? pos_ff + SLW'(1)
                                          : SLW'(first_ff) + SLW'(1);
               end else begin
                  j_in   = j_ff + PAW'(1);
                  pos_in = pos_ff + SLW'(1);
               end
            end else begin
               pos_in = pos_ff + SLW'(1);
            end
         end
         ST_REL_RD: begin
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            if (k_ff + PAW'(1) == j_ff) begin
               j_in     = '0;
               state_in = ST_ISSUE;
            end else begin
               k_in     = k_ff + PAW'(1);
               state_in = ST_REL_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.occurrences     = count_ff;
               rsp_data_in.input_truncated = trunc_ff;
               trunc_in                    = 1'b0;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_len_ff   <= '0;
         pat_len_ff   <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         k_ff         <= '0;
         gap_ff[0]    <= '0;
         gap_ff[1]    <= '0;
         gap_ff[2]    <= '0;
         gap_ff[3]    <= '0;
      end else begin
         state_ff     <= state_in;
         seq_len_ff   <= seq_len_in;
         pat_len_ff   <= pat_len_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAP_MASK_0: gap_ff[0] <= csr_wr_data;
               CSR_GAP_MASK_1: gap_ff[1] <= csr_wr_data;
               CSR_GAP_MASK_2: gap_ff[2] <= csr_wr_data;
               CSR_GAP_MASK_3: gap_ff[3] <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      first_ff    <= first_in;
      clr_ff      <= clr_in;
      gap_ok_ff   <= gap_ok_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_pat_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (PLW'(j_ff) < pat_len_ff))
      else $error("pattern index past pattern length");

   a_release_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL_WR) |-> (k_ff < j_ff))
      else $error("release walked past the partial word");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (pos_ff < seq_len_ff))
      else $error("scan position past sequence length");

endmodule
`default_nettype wire

@@ src/gcoc_ram.sv @@
`default_nettype none
module gcoc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ src/gcoc_step_unit.sv @@
`default_nettype none
module gcoc_step_unit
   import gcoc_pkg::*;
(
   input  wire logic [7:0]   seq_byte,
   input  wire logic [7:0]   pat_byte,
   input  wire logic         used,
   input  wire logic         gap_ok,
   input  wire logic         first_symbol,
   input  wire logic [255:0] gap_set,
   output step_type          step
);

   always_comb begin
      step.hit         = (seq_byte == pat_byte) && !used;
      step.violate     = step.hit && !first_symbol && !gap_ok;
      // A byte passed over without a match lies between two matched positions.
      step.gap_ok_next = step.hit ? 1'b1 : (gap_ok && gap_set[seq_byte]);
   end

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
   import gcoc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SeqDepth = 16384;
   localparam int PatMax = 64;
   localparam int CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_GAP_MASK_0;
   logic [63:0] csr_wr_data = '0;

   gap_constrained_occurrence_counter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's state.
   logic [63:0] gap_set [4];
   logic [7:0] seq_bytes [SeqDepth];
   int seq_len = 0;
   logic [7:0] pat_bytes [PatMax];
   int pat_len = 0;
   logic dropped = 1'b0;
   bit used [SeqDepth];
   int match_at [PatMax];

   req_type pending_words[$];
   rsp_type expected_counts[$];
   int errors = 0;
   int runs_checked = 0;
   int loads_taken = 0;
   int cycles = 0;
   int hold_requests = 0;
   logic req_taken = 1'b0;

   function automatic bit is_gap(logic [7:0] v);
      return gap_set[v[7:6]][v[5:0]];
   endfunction

   function automatic int count_matches();
      int n, m, cnt, pos, j, x;
      bit found, violated;
      n = seq_len;
      m = pat_len;
      cnt = 0;
      pos = 0;
      j = 0;
      for (int i = 0; i < n; i++) used[i] = 0;
      if (n == 0 || m == 0) return 0;
      while (j < m) begin
         found = 0;
         violated = 0;
         while (pos < n) begin
            if (seq_bytes[pos] == pat_bytes[j] && !used[pos]) begin
               if (j > 0) begin
                  for (x = match_at[j-1] + 1; x < pos; x++) begin
                     if (!is_gap(seq_bytes[x])) begin
                        violated = 1;
                        break;
                     end
                  end
               end
               if (violated) begin
                  pos = match_at[0] + 1;
                  for (int k = 0; k < j; k++) used[match_at[k]] = 0;
                  j = 0;
                  break;
               end
               match_at[j] = pos;
               used[pos] = 1;
               found = 1;
               break;
            end
            pos++;
         end
         if (violated) continue;
         if (!found) break;
         if (j == m - 1) begin
            cnt++;
            pos = match_at[0] + 1;
            j = 0;
         end else begin
            pos++;
            j++;
         end
         if (pos >= n) break;
      end
      return cnt;
   endfunction

   function automatic void apply_word(req_type w);
      rsp_type r;
      case (w.mode)
         MODE_SEQ: begin
            if (w.start_new) seq_len = 0;
            if (seq_len < SeqDepth) begin
               seq_bytes[seq_len] = w.symbol;
               seq_len++;
            end else dropped = 1'b1;
            loads_taken++;
         end
         MODE_PAT: begin
            if (w.start_new) pat_len = 0;
            if (pat_len < PatMax) begin
               pat_bytes[pat_len] = w.symbol;
               pat_len++;
            end else dropped = 1'b1;
            loads_taken++;
         end
         MODE_RUN: begin
            r.occurrences = CountWidth'(count_matches());
            r.input_truncated = dropped;
            dropped = 1'b0;
            expected_counts = {expected_counts, r};
         end
         default: ;
      endcase
   endfunction

   // Sampling side: acceptance, prediction and checking.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) apply_word(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected result word occurrences=%0d", rsp_data.occurrences);
            errors++;
         end else begin
            rsp_type e;
            e = expected_counts.pop_front();
            if (rsp_data.occurrences !== e.occurrences) begin
               $error("occurrences expected %0d actual %0d",
                      e.occurrences, rsp_data.occurrences);
               errors++;
            end
            if (rsp_data.input_truncated !== e.input_truncated) begin
               $error("input_truncated expected %0b actual %0b",
                      e.input_truncated, rsp_data.input_truncated);
               errors++;
            end
            runs_checked++;
         end
      end
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // Sender: bursts of words separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left <= burst_left - 1;
         end else req_valid <= 1'b0;
      end
   end

   // Receiver: stall density changes every so often; a long hold on request.
   int stall_pct = 0;
   int hold_left = 0;
   int holds_seen = 0;
   always @(negedge clock) begin
      if (cycles % 256 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      if (holds_seen != hold_requests) begin
         holds_seen <= hold_requests;
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic push(logic [1:0] mode, logic [7:0] sym, logic start);
      req_type w;
      w.mode = mode;
      w.symbol = sym;
      w.start_new = start;
      pending_words = {pending_words, w};
   endtask

   task automatic settle();
      while (pending_words.size() > 0 || req_valid || expected_counts.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_gap(logic [1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      gap_set[idx] = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(logic [63:0] v0, logic [63:0] v1, logic [63:0] v2,
                            logic [63:0] v3);
      write_gap(CSR_GAP_MASK_0, v0);
      write_gap(CSR_GAP_MASK_1, v1);
      write_gap(CSR_GAP_MASK_2, v2);
      write_gap(CSR_GAP_MASK_3, v3);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   logic [7:0] alphabet [4];

   function automatic logic [7:0] pick_symbol();
      if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int items, len;
      for (int i = 0; i < 4; i++) gap_set[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty stores, unused mode, run ignoring its symbol.
      push(MODE_RUN, 8'hff, 1'b1);
      push(MODE_UNUSED, 8'h5a, 1'b1);
      push(MODE_PAT, 8'h00, 1'b1);
      push(MODE_RUN, 8'h00, 1'b0);
      // Byte 255 between two zeros: a violation unless 255 is a gap byte.
      push(MODE_SEQ, 8'h00, 1'b1);
      push(MODE_SEQ, 8'hff, 1'b0);
      push(MODE_SEQ, 8'h00, 1'b0);
      push(MODE_SEQ, 8'h00, 1'b0);
      push(MODE_PAT, 8'h00, 1'b0);
      push(MODE_RUN, 8'h00, 1'b0);
      settle();
      write_all('0, '0, '0, 64'h8000_0000_0000_0000);
      push(MODE_RUN, 8'h11, 1'b1);
      settle();
      write_all('1, '1, '1, '1);
      // Pattern overflow: the flag shows on one run only.
      for (int i = 0; i < PatMax + 1; i++) push(MODE_PAT, 8'(i), i == 0);
      push(MODE_RUN, 8'h00, 1'b0);
      push(MODE_RUN, 8'h00, 1'b0);
      settle();

      // Random part: well-formed load and run sets, some noise.
      items = 0;
      for (int phase = 0; items < 1450; phase++) begin
         for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
         case (phase % 4)
            0: write_all(rand64(), rand64(), rand64(), rand64());
            1: write_all('0, '0, '0, '0);
            2: write_all('1, '1, '1, '1);
            default: begin
               logic [63:0] m [4];
               for (int i = 0; i < 4; i++) m[i] = rand64() & rand64();
               m[alphabet[0][7:6]][alphabet[0][5:0]] = 1'b1;
               m[alphabet[1][7:6]][alphabet[1][5:0]] = 1'b1;
               write_all(m[0], m[1], m[2], m[3]);
            end
         endcase
         if (phase == 2) hold_requests++;
         for (int s = 0; s < 12; s++) begin
            if ($urandom_range(0, 3) != 0) begin
               len = $urandom_range(1, 60);
               for (int i = 0; i < len; i++) push(MODE_SEQ, pick_symbol(), i == 0);
               items += len;
            end
            if ($urandom_range(0, 2) != 0) begin
               len = $urandom_range(1, 5);
               for (int i = 0; i < len; i++)
                  push(MODE_PAT, pick_symbol(), i == 0 && $urandom_range(0, 4) != 0);
               items += len;
            end
            if ($urandom_range(0, 29) == 0) begin
               for (int i = 0; i < PatMax + 2; i++) push(MODE_PAT, pick_symbol(), 1'b0);
               items += PatMax + 2;
            end
            if ($urandom_range(0, 9) == 0) begin
               push(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               items++;
            end
            push(MODE_RUN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            items++;
         end
         settle();
      end

      repeat (50) @(posedge clock);
      $display("checked %0d run results over %0d load words", runs_checked, loads_taken);
      if (errors == 0 && expected_counts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
src/gcoc_pkg.sv
src/gcoc_ram.sv
src/gcoc_step_unit.sv
src/gap_constrained_occurrence_counter_core.sv
test/tb.sv
